### hdl/bbpe_pkg.sv
// Shared types and constants for the bicubic Bezier patch evaluator.
// Used by every module in the hdl folder; depends on nothing else.
package bbpe_pkg;

  // Opcode of an input request.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_TESS   = 2'd0;
  localparam logic [1:0] REG_MIRROR = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam int MAG_W = 40;  // cross product magnitude
  localparam int NRM_W = 24;  // normalized magnitude, in [2^23, 2^24)
  localparam int SQ_W  = 50;  // sum of squares
  localparam int LEN_W = 25;  // square root of the sum of squares
  localparam int QT_W  = 15;  // normal component magnitude, at most 2^14
  localparam int NUM_W = 39;  // divider numerator

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic [15:0]        ONE_Q15 = 16'd32768;

  typedef logic [30:0]        bw_t;   // Bernstein weight, Q30
  typedef logic signed [31:0] dw_t;   // derivative weight, Q30

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
  } vtx_t;

  // Travels alongside the divider.
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
    vtx_t       vtx;
  } nsd_t;

  // Travels alongside the square root unit.
  typedef struct packed {
    logic [2:0][NRM_W-1:0] mag;
    nsd_t                  nsd;
  } sqs_t;

endpackage

### hdl/bbpe_weights.sv
// Two-stage pipeline that turns a parameter t (Q1.15) into cubic Bernstein
// weights and derivative weights, both Q30. Depends on bbpe_pkg.
module bbpe_weights import bbpe_pkg::*; (
  input  logic        clk,
  input  logic [15:0] t,
  output bw_t         bw [4],
  output dw_t         dw [4]
);

  logic [16:0] s_c;
  logic [16:0] t_c;
  logic [33:0] ss_f;
  logic [33:0] ts_f;
  logic [33:0] tq_f;
  logic [16:0] s1;
  logic [16:0] t1;
  logic [30:0] ss;
  logic [30:0] ts;
  logic [30:0] tq;
  logic [47:0] p0;
  logic [47:0] p1;
  logic [47:0] p2;
  logic [47:0] p3;
  logic [49:0] p1x3;
  logic [49:0] p2x3;

  assign t_c = {1'b0, t};
  assign s_c = 17'd32768 - t_c;

  always_comb begin
    ss_f = s_c * s_c;
    ts_f = s_c * t_c;
    tq_f = t_c * t_c;
  end

  always_ff @(posedge clk) begin
    s1 <= s_c;
    t1 <= t_c;
    ss <= ss_f[30:0];
    ts <= ts_f[30:0];
    tq <= tq_f[30:0];
  end

  always_comb begin
    p0   = ss * s1;
    p1   = ts * s1;
    p2   = ts * t1;
    p3   = tq * t1;
    p1x3 = {2'b0, p1} + {1'b0, p1, 1'b0};
    p2x3 = {2'b0, p2} + {1'b0, p2, 1'b0};
  end

  // Weights are rounded half up from Q45 to Q30.
  always_ff @(posedge clk) begin
    bw[0] <= 31'(({2'b0, p0} + 50'd16384) >> 15);
    bw[1] <= 31'((p1x3 + 50'd16384) >> 15);
    bw[2] <= 31'((p2x3 + 50'd16384) >> 15);
    bw[3] <= 31'(({2'b0, p3} + 50'd16384) >> 15);
    dw[0] <= -$signed({1'b0, ss});
    dw[1] <= $signed({1'b0, ss}) - $signed({ts, 1'b0});
    dw[2] <= $signed({ts, 1'b0}) - $signed({1'b0, tq});
    dw[3] <= $signed({1'b0, tq});
  end

endmodule

### hdl/bbpe_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband
// word carried in step. Depends on bbpe_pkg.
module bbpe_isqrt import bbpe_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [LEN_W-1:0]  root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = LEN_W;
  localparam int REM_W = LEN_W + 2;

  logic              vld [STEPS];
  logic [SQ_W-1:0]   rad [STEPS];
  logic [REM_W-1:0]  rem [STEPS];
  logic [LEN_W-1:0]  rt  [STEPS];
  logic [SIDE_W-1:0] sd  [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic              p_vld;
    logic [SQ_W-1:0]   p_rad;
    logic [REM_W-1:0]  p_rem;
    logic [LEN_W-1:0]  p_rt;
    logic [SIDE_W-1:0] p_sd;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    if (j == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rad = radicand;
      assign p_rem = '0;
      assign p_rt  = '0;
      assign p_sd  = in_side;
    end else begin : g_next
      assign p_vld = vld[j-1];
      assign p_rad = rad[j-1];
      assign p_rem = rem[j-1];
      assign p_rt  = rt[j-1];
      assign p_sd  = sd[j-1];
    end

    assign rem_sh = {p_rem, p_rad[SQ_W-1 -: 2]};
    assign trial  = {2'b0, p_rt, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rad[j] <= {p_rad[SQ_W-3:0], 2'b00};
      sd[j]  <= p_sd;
      if (rem_sh >= trial) begin
        rem[j] <= REM_W'(rem_sh - trial);
        rt[j]  <= {p_rt[LEN_W-2:0], 1'b1};
      end else begin
        rem[j] <= REM_W'(rem_sh);
        rt[j]  <= {p_rt[LEN_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign root      = rt[STEPS-1];
  assign out_side  = sd[STEPS-1];

endmodule

### hdl/bbpe_div3.sv
// Pipelined restoring divider: three numerators over one shared divisor,
// one quotient bit per stage, sideband carried in step. Depends on bbpe_pkg.
module bbpe_div3 import bbpe_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num [3],
  input  logic [LEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QT_W-1:0]   quo [3],
  output logic [SIDE_W-1:0] out_side
);

  logic              vld [QT_W];
  logic [NUM_W-1:0]  rem [QT_W][3];
  logic [QT_W-1:0]   qt  [QT_W][3];
  logic [LEN_W-1:0]  dn  [QT_W];
  logic [SIDE_W-1:0] sd  [QT_W];

  for (genvar j = 0; j < QT_W; j++) begin : g_step
    logic              p_vld;
    logic [NUM_W-1:0]  p_rem [3];
    logic [QT_W-1:0]   p_qt  [3];
    logic [LEN_W-1:0]  p_dn;
    logic [SIDE_W-1:0] p_sd;
    logic [NUM_W-1:0]  dsh;

    if (j == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_dn  = den;
      assign p_sd  = in_side;
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign p_rem[c] = num[c];
        assign p_qt[c]  = '0;
      end
    end else begin : g_next
      assign p_vld = vld[j-1];
      assign p_dn  = dn[j-1];
      assign p_sd  = sd[j-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign p_rem[c] = rem[j-1][c];
        assign p_qt[c]  = qt[j-1][c];
      end
    end

    assign dsh = NUM_W'(p_dn) << (QT_W - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      dn[j] <= p_dn;
      sd[j] <= p_sd;
      for (int c = 0; c < 3; c++) begin
        if (p_rem[c] >= dsh) begin
          rem[j][c] <= p_rem[c] - dsh;
          qt[j][c]  <= {p_qt[c][QT_W-2:0], 1'b1};
        end else begin
          rem[j][c] <= p_rem[c];
          qt[j][c]  <= {p_qt[c][QT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[QT_W-1];
  assign out_side  = sd[QT_W-1];
  for (genvar c = 0; c < 3; c++) begin : g_out
    assign quo[c] = qt[QT_W-1][c];
  end

endmodule

### hdl/bicubic_bezier_patch_evaluator_unit.sv
// Top level of the bicubic Bezier patch evaluator: request decode, patch
// storage, surface and normal pipeline. Depends on bbpe_pkg, bbpe_weights,
// bbpe_isqrt and bbpe_div3.
//
// A request is taken at every rising edge where start is high; busy is never
// raised, so one request can be issued in every clock cycle. A load request
// (op = 0) writes one control point and produces no result. An evaluate
// request (op = 1) produces exactly one vertex: done pulses for one cycle,
// with position, normal and texture coordinates on the result ports. The
// request passes through the surface pipeline (17 stages), the square root
// unit (one stage per bit of the 25-bit length) and the normalizing divider
// (one stage per bit of the 15-bit quotient), then the output register. The
// receiver cannot hold a result off, so it must take done and the result
// ports as they come. Loads and evaluates may be mixed freely: each evaluate
// sees exactly the loads issued before it. Configuration is written through
// cfg_write, cfg_index and cfg_data and must only change while no evaluate
// is in flight.
module bicubic_bezier_patch_evaluator_unit import bbpe_pkg::*; #(
  parameter int MAX_TESS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               op,
  input  logic [3:0]         point_index,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  logic [6:0]         row_index,
  input  logic [6:0]         col_index,
  output logic               done,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [15:0]        tex_u,
  output logic [15:0]        tex_v
);

  // Grid step width and reciprocal parameters. The parameter u = i/T is
  // formed as a multiply by ceil(2^RK/T), which is exact because the
  // numerator times T stays below 2^RK.
  localparam int TW  = $clog2(MAX_TESS + 1);
  localparam int NW  = TW + 15;
  localparam int RK  = 2 * TW + 15;
  localparam int RW  = RK + 1;
  localparam int PW  = NW + RW;
  localparam int LAT = 18 + LEN_W + QT_W;

  // The block never stalls; every request is taken.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [6:0]  tessellation;
  logic        mirrored;
  logic [15:0] degenerate_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      tessellation         <= 7'd1;
      mirrored             <= 1'b0;
      degenerate_threshold <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TESS:   tessellation         <= cfg_data[6:0];
        REG_MIRROR: mirrored             <= cfg_data[0];
        REG_THRESH: degenerate_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Reciprocal table for the grid step, computed at elaboration.
  // ---------------------------------------------------------------------
  logic [RW-1:0] rcp_tab [MAX_TESS+1];
  assign rcp_tab[0] = '0;
  for (genvar d = 1; d <= MAX_TESS; d++) begin : g_rcp
    localparam logic [63:0] RV = ((64'd1 << RK) + 64'(d) - 64'd1) / 64'(d);
    assign rcp_tab[d] = RW'(RV);
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp the step count and the indices, build numerators.
  // ---------------------------------------------------------------------
  logic [TW-1:0] tt;
  logic [TW-1:0] ri;
  logic [TW-1:0] ci;
  logic [NW-1:0] nu_c;
  logic [NW-1:0] nv_c;

  always_comb begin
    if (tessellation == 7'd0) begin
      tt = TW'(1);
    end else if (int'(tessellation) > MAX_TESS) begin
      tt = TW'(MAX_TESS);
    end else begin
      tt = TW'(tessellation);
    end
    ri   = (int'(row_index) > int'(tt)) ? tt : TW'(row_index);
    ci   = (int'(col_index) > int'(tt)) ? tt : TW'(col_index);
    nu_c = (NW'(ri) << 15) + NW'(tt >> 1);
    nv_c = (NW'(ci) << 15) + NW'(tt >> 1);
  end

  // Eval valid bits for the surface pipeline, stages 1 to 17.
  logic [16:0] ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0;
    end else begin
      ev <= {ev[15:0], accept && (op_t'(op) == OP_EVAL)};
    end
  end

  logic [NW-1:0] nu1;
  logic [NW-1:0] nv1;
  logic [RW-1:0] rcp1;

  always_ff @(posedge clk) begin
    nu1  <= nu_c;
    nv1  <= nv_c;
    rcp1 <= rcp_tab[tt];
  end

  // Load requests travel down to stage 5 and then write the control points
  // read by stage 6, so that an evaluate sees exactly the loads issued before it.
  logic [4:0]         ld_v;
  logic [3:0]         ld_idx [5];
  logic signed [15:0] ld_pt  [5][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v <= '0;
    end else begin
      ld_v <= {ld_v[3:0], accept && (op_t'(op) == OP_LOAD)};
    end
  end

  always_ff @(posedge clk) begin
    ld_idx[0]   <= point_index;
    ld_pt[0][0] <= point_x;
    ld_pt[0][1] <= point_y;
    ld_pt[0][2] <= point_z;
    for (int k = 1; k < 5; k++) begin
      ld_idx[k] <= ld_idx[k-1];
      ld_pt[k]  <= ld_pt[k-1];
    end
  end

  // Stage 2: reciprocal multiply. Stage 3: u and v in Q1.15.
  logic [PW-1:0] pu2;
  logic [PW-1:0] pv2;
  logic [15:0]   uq3;
  logic [15:0]   vq3;

  always_ff @(posedge clk) begin
    pu2 <= PW'(nu1) * PW'(rcp1);
    pv2 <= PW'(nv1) * PW'(rcp1);
    uq3 <= 16'(pu2 >> RK);
    vq3 <= 16'(pv2 >> RK);
  end

  // Texture coordinates wait in a short delay line (stages 4 to 8).
  logic [15:0] td_u [5];
  logic [15:0] td_v [5];

  always_ff @(posedge clk) begin
    td_u[0] <= uq3;
    td_v[0] <= vq3;
    for (int k = 1; k < 5; k++) begin
      td_u[k] <= td_u[k-1];
      td_v[k] <= td_v[k-1];
    end
  end

  // Stages 4 and 5: weights.
  bw_t bu [4];
  bw_t bv [4];
  dw_t du [4];
  dw_t dv [4];

  bbpe_weights u_wgt_u (.clk(clk), .t(uq3), .bw(bu), .dw(du));
  bbpe_weights u_wgt_v (.clk(clk), .t(vq3), .bw(bv), .dw(dv));

  // ---------------------------------------------------------------------
  // Control point store, written by loads leaving stage 5.
  // ---------------------------------------------------------------------
  logic signed [15:0] cp [16][3];

  always_ff @(posedge clk) begin
    if (ld_v[4]) begin
      cp[ld_idx[4]] <= ld_pt[4];
    end
  end

  // Stage 6: row curve products (over u) and column curve products (over v).
  logic signed [47:0] rprod [3][4][4];
  logic signed [47:0] cprod [3][4][4];
  bw_t                bv6 [4];
  dw_t                du6 [4];
  dw_t                dv6 [4];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          rprod[c][a][b] <= cp[4*a+b][c] * $signed({1'b0, bu[b]});
          cprod[c][a][b] <= cp[4*b+a][c] * $signed({1'b0, bv[b]});
        end
      end
    end
    bv6 <= bv;
    du6 <= du;
    dv6 <= dv;
  end

  // Stage 7: curve points, rounded to Q12.
  logic signed [49:0] rsum [3][4];
  logic signed [49:0] csum [3][4];
  logic signed [29:0] prow [3][4];
  logic signed [29:0] qcol [3][4];
  bw_t                bv7 [4];
  dw_t                du7 [4];
  dw_t                dv7 [4];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 4; a++) begin
        rsum[c][a] = rprod[c][a][0] + rprod[c][a][1] + rprod[c][a][2] + rprod[c][a][3];
        csum[c][a] = cprod[c][a][0] + cprod[c][a][1] + cprod[c][a][2] + cprod[c][a][3];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 4; a++) begin
        prow[c][a] <= 30'((rsum[c][a] + 50'sd131072) >>> 18);
        qcol[c][a] <= 30'((csum[c][a] + 50'sd131072) >>> 18);
      end
    end
    bv7 <= bv6;
    du7 <= du6;
    dv7 <= dv6;
  end

  // Stage 8: position and tangent products.
  logic signed [61:0] pp  [3][4];
  logic signed [61:0] t1p [3][4];
  logic signed [61:0] t2p [3][4];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 4; a++) begin
        pp[c][a]  <= prow[c][a] * $signed({1'b0, bv7[a]});
        t1p[c][a] <= prow[c][a] * dv7[a];
        t2p[c][a] <= qcol[c][a] * du7[a];
      end
    end
  end

  // Stage 9: position (saturated) and tangents, rounded to Q0.
  logic signed [63:0] psum [3];
  logic signed [63:0] s1sum [3];
  logic signed [63:0] s2sum [3];
  logic signed [63:0] prnd [3];
  logic signed [15:0] pos_c [3];
  logic signed [19:0] t1 [3];
  logic signed [19:0] t2 [3];
  vtx_t               vtx_d [9];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      psum[c]  = pp[c][0] + pp[c][1] + pp[c][2] + pp[c][3];
      s1sum[c] = t1p[c][0] + t1p[c][1] + t1p[c][2] + t1p[c][3];
      s2sum[c] = t2p[c][0] + t2p[c][1] + t2p[c][2] + t2p[c][3];
      prnd[c]  = (psum[c] + 64'sd2199023255552) >>> 42;
      if (prnd[c] > 64'sd32767) begin
        pos_c[c] = 16'sd32767;
      end else if (prnd[c] < -64'sd32768) begin
        pos_c[c] = -16'sd32768;
      end else begin
        pos_c[c] = 16'(prnd[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      t1[c] <= 20'((s1sum[c] + 64'sd2199023255552) >>> 42);
      t2[c] <= 20'((s2sum[c] + 64'sd2199023255552) >>> 42);
    end
    vtx_d[0] <= '{pos_x: pos_c[0], pos_y: pos_c[1], pos_z: pos_c[2],
                  tex_u: td_u[4], tex_v: td_v[4]};
    for (int k = 1; k < 9; k++) begin
      vtx_d[k] <= vtx_d[k-1];
    end
  end

  // Stage 10: cross product partial products.
  logic signed [39:0] xp [6];

  always_ff @(posedge clk) begin
    xp[0] <= t1[1] * t2[2];
    xp[1] <= t1[2] * t2[1];
    xp[2] <= t1[2] * t2[0];
    xp[3] <= t1[0] * t2[2];
    xp[4] <= t1[0] * t2[1];
    xp[5] <= t1[1] * t2[0];
  end

  // Stage 11: cross product, split into magnitude and sign.
  logic signed [40:0] cr [3];
  logic [MAG_W-1:0]   mag11 [3];
  logic [2:0]         neg11;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cr[c] = xp[2*c] - xp[2*c+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      mag11[c] <= cr[c][40] ? MAG_W'(-cr[c]) : MAG_W'(cr[c]);
      neg11[c] <= cr[c][40];
    end
  end

  // Stage 12: largest magnitude and the degenerate test.
  logic [MAG_W-1:0] m_c;
  logic             degen_c;
  logic [MAG_W-1:0] mag12 [3];
  logic [MAG_W-1:0] m12;
  logic [2:0]       neg_d [6];
  logic             degen_d [6];

  always_comb begin
    m_c = mag11[0];
    if (mag11[1] > m_c) m_c = mag11[1];
    if (mag11[2] > m_c) m_c = mag11[2];
    degen_c = (mag11[0] <= MAG_W'(degenerate_threshold))
           && (mag11[1] <= MAG_W'(degenerate_threshold))
           && (mag11[2] <= MAG_W'(degenerate_threshold));
  end

  always_ff @(posedge clk) begin
    mag12      <= mag11;
    m12        <= m_c;
    neg_d[0]   <= neg11;
    degen_d[0] <= degen_c;
    for (int k = 1; k < 6; k++) begin
      neg_d[k]   <= neg_d[k-1];
      degen_d[k] <= degen_d[k-1];
    end
  end

  // Stage 13: leading one within each byte of the largest magnitude.
  localparam int NB = MAG_W / 8;
  logic             nz_c [NB];
  logic [2:0]       bp_c [NB];
  logic             nz13 [NB];
  logic [2:0]       bp13 [NB];
  logic [MAG_W-1:0] mag13 [3];

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      nz_c[k] = |m12[8*k +: 8];
      bp_c[k] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (m12[8*k+i]) bp_c[k] = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    nz13  <= nz_c;
    bp13  <= bp_c;
    mag13 <= mag12;
  end

  // Stage 14: bit position of the leading one.
  logic [5:0]       p_c;
  logic [5:0]       p14;
  logic [MAG_W-1:0] mag14 [3];

  always_comb begin
    p_c = 6'd0;
    for (int k = 0; k < NB; k++) begin
      if (nz13[k]) p_c = 6'(8*k) + 6'(bp13[k]);
    end
  end

  always_ff @(posedge clk) begin
    p14   <= p_c;
    mag14 <= mag13;
  end

  // Stage 15: common shift that puts the largest magnitude in [2^23, 2^24).
  logic [MAG_W-1:0] sh_c [3];
  logic [NRM_W-1:0] nm15 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (p14 >= 6'd23) begin
        sh_c[c] = mag14[c] >> (p14 - 6'd23);
      end else begin
        sh_c[c] = mag14[c] << (6'd23 - p14);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      nm15[c] <= sh_c[c][NRM_W-1:0];
    end
  end

  // Stage 16: squares. Stage 17: sum of squares.
  logic [2*NRM_W-1:0] sq16 [3];
  logic [NRM_W-1:0]   nm16 [3];
  logic [SQ_W-1:0]    sumsq17;
  logic [NRM_W-1:0]   nm17 [3];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sq16[c] <= nm15[c] * nm15[c];
    end
    nm16    <= nm15;
    sumsq17 <= SQ_W'(sq16[0]) + SQ_W'(sq16[1]) + SQ_W'(sq16[2]);
    nm17    <= nm16;
  end

  // ---------------------------------------------------------------------
  // Vector length, then each component over the length.
  // ---------------------------------------------------------------------
  sqs_t             sq_in;
  sqs_t             sq_out;
  logic             sq_valid;
  logic [LEN_W-1:0] len;

  always_comb begin
    sq_in.mag[0]    = nm17[0];
    sq_in.mag[1]    = nm17[1];
    sq_in.mag[2]    = nm17[2];
    sq_in.nsd.neg   = neg_d[5];
    sq_in.nsd.degen = degen_d[5];
    sq_in.nsd.vtx   = vtx_d[8];
  end

  bbpe_isqrt #(.SIDE_W($bits(sqs_t))) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ev[16]),
    .radicand (sumsq17),
    .in_side  (sq_in),
    .out_valid(sq_valid),
    .root     (len),
    .out_side (sq_out)
  );

  // Numerator mag * 2^14 + len / 2 gives a quotient rounded half up.
  logic [NUM_W-1:0] dnum [3];
  nsd_t             dv_side;
  logic             dv_valid;
  logic [QT_W-1:0]  quo [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dnum[c] = NUM_W'({sq_out.mag[c], 14'b0}) + NUM_W'(len >> 1);
    end
  end

  bbpe_div3 #(.SIDE_W($bits(nsd_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .num      (dnum),
    .den      (len),
    .in_side  (sq_out.nsd),
    .out_valid(dv_valid),
    .quo      (quo),
    .out_side (dv_side)
  );

  // ---------------------------------------------------------------------
  // Output register. The emitted normal is the negated patch normal; the
  // mirror setting cancels that negation. A degenerate normal points up or
  // down depending on the sign of the position's y component.
  // ---------------------------------------------------------------------
  logic signed [15:0] nrm_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dv_side.neg[c] ^ ~mirrored) begin
        nrm_c[c] = -$signed({1'b0, quo[c]});
      end else begin
        nrm_c[c] = $signed({1'b0, quo[c]});
      end
    end
    if (dv_side.degen) begin
      nrm_c[0] = 16'sd0;
      nrm_c[1] = dv_side.vtx.pos_y[15] ? ONE_Q14 : -ONE_Q14;
      nrm_c[2] = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    pos_x  <= dv_side.vtx.pos_x;
    pos_y  <= dv_side.vtx.pos_y;
    pos_z  <= dv_side.vtx.pos_z;
    norm_x <= nrm_c[0];
    norm_y <= nrm_c[1];
    norm_z <= nrm_c[2];
    tex_u  <= mirrored ? (ONE_Q15 - dv_side.vtx.tex_u) : dv_side.vtx.tex_u;
    tex_v  <= dv_side.vtx.tex_v;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // Every result traces back to an evaluate request a fixed latency earlier.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && (op_t'(op) == OP_EVAL), LAT))
    else $error("result without a matching evaluate request");

  // A normalized vector has a length of at least 2^23 unless degenerate.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (sq_valid && !sq_out.nsd.degen) |-> (len[LEN_W-1:LEN_W-2] != 2'b00))
    else $error("normalization left the vector length out of range");

  // Normal components never exceed one in magnitude.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((norm_x >= -ONE_Q14) && (norm_x <= ONE_Q14)
           && (norm_y >= -ONE_Q14) && (norm_y <= ONE_Q14)
           && (norm_z >= -ONE_Q14) && (norm_z <= ONE_Q14)))
    else $error("normal component out of range");

endmodule

### tb/bicubic_bezier_patch_evaluator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bicubic Bezier patch evaluator unit.
// Depends on bbpe_pkg and the unit itself; a built-in fixed-point predictor
// computes each expected vertex and a scoreboard class checks every result.

module bicubic_bezier_patch_evaluator_unit_tb;
  import bbpe_pkg::*;

  localparam int MAX_TESS  = 64;
  localparam int LIMIT_CYC = 400000;

  typedef logic [7:0][15:0] vertex_t;

  // Holds the patch state seen by the unit and the vertices still to come.
  class patch_scoreboard;
    longint  pts[16][3];
    int      tess_reg;
    bit      mirror_reg;
    longint  thresh_reg;
    vertex_t vertices_due[$];
    int      errors;

    function new();
      tess_reg   = 1;
      mirror_reg = 0;
      thresh_reg = 1;
      errors     = 0;
      foreach (pts[a, c]) pts[a][c] = 0;
    endfunction

    // Rounds x / 2^k half up; the arithmetic shift floors.
    function longint round_shift(longint x, int k);
      return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
        if (x >= res + bit_v) begin
          x -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    // Bernstein weights in Q30 and derivative weights in Q30 for t in Q15.
    function void basis(longint t, output longint bw[4], output longint dw[4]);
      longint s;
      s = 32768 - t;
      bw[0] = round_shift(s * s * s, 15);
      bw[1] = round_shift(3 * t * s * s, 15);
      bw[2] = round_shift(3 * t * t * s, 15);
      bw[3] = round_shift(t * t * t, 15);
      dw[0] = -(s * s);
      dw[1] = s * s - 2 * t * s;
      dw[2] = 2 * t * s - t * t;
      dw[3] = t * t;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == REG_TESS) tess_reg = val[6:0];
      else if (idx == REG_MIRROR) mirror_reg = val[0];
      else if (idx == REG_THRESH) thresh_reg = val;
    endfunction

    // Notes an accepted request; an evaluate queues its expected vertex.
    function void note_request(op_t opc, logic [3:0] slot, logic signed [15:0] px,
                               logic signed [15:0] py, logic signed [15:0] pz,
                               logic [6:0] ri_in, logic [6:0] ci_in);
      longint tt, ri, ci, uq, vq;
      longint bu[4], du[4], bv[4], dv[4];
      longint pos[3], tu[3], tv[3], cr[3], nrm[3];
      longint unsigned mag[3], m, len;
      longint prow[4], qcol[4], sp, s1, s2, sr, sc, q;
      bit degen;
      vertex_t vx;
      if (opc == OP_LOAD) begin
        pts[slot][0] = px;
        pts[slot][1] = py;
        pts[slot][2] = pz;
        return;
      end
      tt = tess_reg;
      if (tt < 1) tt = 1;
      if (tt > MAX_TESS) tt = MAX_TESS;
      ri = ri_in;
      ci = ci_in;
      if (ri > tt) ri = tt;
      if (ci > tt) ci = tt;
      uq = (ri * 32768 + tt / 2) / tt;
      vq = (ci * 32768 + tt / 2) / tt;
      basis(uq, bu, du);
      basis(vq, bv, dv);
      for (int c = 0; c < 3; c++) begin
        sp = 0; s1 = 0; s2 = 0;
        for (int a = 0; a < 4; a++) begin
          sr = 0; sc = 0;
          for (int b = 0; b < 4; b++) begin
            sr += pts[a * 4 + b][c] * bu[b];
            sc += pts[b * 4 + a][c] * bv[b];
          end
          prow[a] = round_shift(sr, 18);
          qcol[a] = round_shift(sc, 18);
        end
        for (int a = 0; a < 4; a++) begin
          sp += prow[a] * bv[a];
          s1 += prow[a] * dv[a];
          s2 += qcol[a] * du[a];
        end
        pos[c] = round_shift(sp, 42);
        if (pos[c] > 32767) pos[c] = 32767;
        if (pos[c] < -32768) pos[c] = -32768;
        tu[c] = round_shift(s1, 42);
        tv[c] = round_shift(s2, 42);
      end
      cr[0] = tu[1] * tv[2] - tu[2] * tv[1];
      cr[1] = tu[2] * tv[0] - tu[0] * tv[2];
      cr[2] = tu[0] * tv[1] - tu[1] * tv[0];
      m = 0;
      degen = 1;
      for (int c = 0; c < 3; c++) begin
        mag[c] = cr[c] < 0 ? -cr[c] : cr[c];
        if (mag[c] > thresh_reg) degen = 0;
        if (mag[c] > m) m = mag[c];
      end
      if (degen || m == 0) begin
        nrm[0] = 0;
        nrm[1] = pos[1] < 0 ? 16384 : -16384;
        nrm[2] = 0;
      end else begin
        // Bring the largest magnitude into [2^23, 2^24) with a common shift.
        while (m >= (64'd1 << 24)) begin
          m >>= 1;
          for (int c = 0; c < 3; c++) mag[c] >>= 1;
        end
        while (m < (64'd1 << 23)) begin
          m <<= 1;
          for (int c = 0; c < 3; c++) mag[c] <<= 1;
        end
        len = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        if (len == 0) len = 1;
        for (int c = 0; c < 3; c++) begin
          q = (mag[c] * 16384 + len / 2) / len;
          if (cr[c] < 0) q = -q;
          nrm[c] = mirror_reg ? q : -q;
        end
      end
      for (int c = 0; c < 3; c++) begin
        vx[c]     = pos[c][15:0];
        vx[3 + c] = nrm[c][15:0];
      end
      vx[6] = mirror_reg ? 16'(32768 - uq) : 16'(uq);
      vx[7] = 16'(vq);
      vertices_due.insert(vertices_due.size(), vx);
    endfunction

    // Compares one delivered vertex against the oldest expectation.
    function void check_vertex(vertex_t got);
      string names[8] = '{"pos_x", "pos_y", "pos_z", "norm_x", "norm_y", "norm_z",
                          "tex_u", "tex_v"};
      vertex_t want;
      if (vertices_due.size() == 0) begin
        $display("%0t: unexpected vertex, none outstanding (got %h)", $time, got);
        errors++;
        return;
      end
      want = vertices_due.pop_front();
      for (int f = 0; f < 8; f++)
        if (want[f] !== got[f]) begin
          $display("%0t: %s mismatch, expected %h, actual %h", $time, names[f],
                   want[f], got[f]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_TESS;
  logic [15:0] cfg_data = '0;
  logic op = OP_LOAD;
  logic [3:0] point_index = '0;
  logic signed [15:0] point_x = '0, point_y = '0, point_z = '0;
  logic [6:0] row_index = '0, col_index = '0;
  logic done;
  logic signed [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
  logic [15:0] tex_u, tex_v;

  patch_scoreboard sb = new();
  bit  idle_on = 1;
  int  cycle_count = 0;

  bicubic_bezier_patch_evaluator_unit #(.MAX_TESS(MAX_TESS)) DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Global watchdog; the run must finish well before this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYC) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver cannot hold results off, so every done pulse is checked.
  always @(posedge clk)
    if (!rst && done)
      sb.check_vertex({tex_v, tex_u, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x});

  // Issues one request, with a random idle gap before it when enabled, and
  // holds it until the unit takes it.
  task automatic issue(op_t opc, logic [3:0] slot, logic signed [15:0] px,
                       logic signed [15:0] py, logic signed [15:0] pz,
                       logic [6:0] ri, logic [6:0] ci);
    if (idle_on)
      while ($urandom_range(99) < 22) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start <= 1'b1;
    op <= opc;
    point_index <= slot;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    row_index <= ri;
    col_index <= ci;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(opc, slot, px, py, pz, ri, ci);
  endtask

  task automatic load_pt(int slot, logic signed [15:0] px, logic signed [15:0] py,
                         logic signed [15:0] pz);
    issue(OP_LOAD, slot[3:0], px, py, pz, 7'($urandom), 7'($urandom));
  endtask

  task automatic evaluate(int ri, int ci);
    issue(OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
          ri[6:0], ci[6:0]);
  endtask

  // Control point coordinate: mostly within one unit, sometimes full range or
  // an extreme, so that saturation of the position is reached.
  function automatic logic signed [15:0] rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 16'($urandom_range(8192) - 4096);
    if (sel < 85) return 16'($urandom);
    case ($urandom_range(2))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'sh0000;
    endcase
  endfunction

  // Stops sending, lets every outstanding vertex arrive and then covers the
  // pipeline depth before any register may change.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.vertices_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_regs(int tess, int mir, int thr);
    cfg_write <= 1'b1;
    cfg_index <= REG_TESS;
    cfg_data <= 16'(tess);
    @(posedge clk);
    sb.write_reg(REG_TESS, 16'(tess));
    cfg_index <= REG_MIRROR;
    cfg_data <= 16'(mir);
    @(posedge clk);
    sb.write_reg(REG_MIRROR, 16'(mir));
    cfg_index <= REG_THRESH;
    cfg_data <= 16'(thr);
    @(posedge clk);
    sb.write_reg(REG_THRESH, 16'(thr));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int tess, n_eval;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at reset settings: a flat all-zero patch is degenerate
    // with pos_y at zero, so the normal points down; then the most negative
    // points flip it up, and indices beyond the tessellation saturate.
    for (int s = 0; s < 16; s++) load_pt(s, 16'sh0000, 16'sh0000, 16'sh0000);
    evaluate(0, 0);
    evaluate(1, 1);
    for (int s = 0; s < 16; s++) load_pt(s, 16'sh8000, 16'sh8000, 16'sh8000);
    evaluate(64, 0);
    evaluate(0, 64);
    drain();

    // The heaviest settings: finest grid, mirrored, zero threshold. A curved
    // patch at full scale exercises the normal and position saturation.
    set_regs(MAX_TESS, 1, 0);
    for (int s = 0; s < 16; s++)
      load_pt(s, 16'((s % 4) * 16'sh2AAA - 16'sh4000), 16'((s * 1237) % 20000 - 10000),
              16'((s / 4) * 16'sh2AAA - 16'sh4000));
    load_pt(5, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    evaluate(0, 0);
    evaluate(64, 64);
    evaluate(32, 17);
    drain();

    // Random phases: each sets new registers, loads a full patch and then
    // evaluates grid vertices with an occasional point reload mixed in.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_regs(1, 0, 65535);
        1: set_regs(7, 0, 1000);
        2: set_regs(MAX_TESS, 0, 1);
        default: set_regs($urandom_range(MAX_TESS, 1), $urandom_range(1),
                          $urandom_range(3) == 0 ? $urandom_range(65535)
                                                 : $urandom_range(4096));
      endcase
      tess = sb.tess_reg;
      idle_on = (ph != 4);
      for (int s = 0; s < 16; s++)
        load_pt(s, rand_coord(), rand_coord(), rand_coord());
      n_eval = 42;
      for (int k = 0; k < n_eval; k++) begin
        if ($urandom_range(9) == 0)
          load_pt($urandom_range(15), rand_coord(), rand_coord(), rand_coord());
        else if ($urandom_range(19) == 0)
          evaluate($urandom_range(MAX_TESS), $urandom_range(MAX_TESS));
        else
          evaluate($urandom_range(tess), $urandom_range(tess));
      end
      drain();
    end

    idle_on = 1;
    repeat (2000) @(posedge clk);
    if (sb.errors == 0 && sb.vertices_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.vertices_due.size() != 0)
        $display("%0t: %0d vertices never arrived", $time, sb.vertices_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
